[hdl/push_button_fading_dimmer_assert.svh]
// Assertion helpers for the dimmer RTL
`ifndef PUSH_BUTTON_FADING_DIMMER_ASSERT_SVH
`define PUSH_BUTTON_FADING_DIMMER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define PBFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbfd assertion failed");

// Next-cycle implication, disabled while in reset
`define PBFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbfd assertion failed");

`endif

[hdl/pbfd_pkg.sv]
`default_nettype none

package pbfd_pkg;

  // Configuration register file geometry
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int TICK_W     = 16;
  localparam int STEP_W     = 8;
  localparam int BYTE_W     = 8;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE    = 3'd0,
    REG_FADE_PERIOD = 3'd1,
    REG_HOLD_LIMIT  = 3'd2,
    REG_FADE_STEP   = 3'd3,
    REG_SWEEP_STEP  = 3'd4
  } cfg_reg_e;

  // Reset values of the registers
  localparam logic [TICK_W-1:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [TICK_W-1:0] FADE_PERIOD_RST = 16'd25;
  localparam logic [TICK_W-1:0] HOLD_LIMIT_RST  = 16'd5000;
  localparam logic [STEP_W-1:0] FADE_STEP_RST   = 8'd4;
  localparam logic [STEP_W-1:0] SWEEP_STEP_RST  = 8'd1;

  typedef struct packed {
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] fade_period_ticks;
    logic [TICK_W-1:0] hold_limit_ticks;
    logic [STEP_W-1:0] fade_step;
    logic [STEP_W-1:0] sweep_step;
  } cfg_t;

  // One tick as seen by the core
  typedef struct packed {
    logic              button_level;
    logic              on_write;
    logic              on_value;
    logic              max_write;
    logic [BYTE_W-1:0] max_value;
  } tick_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] pwm_level;
    logic              power_enable;
    logic              lamp_on;
    logic [BYTE_W-1:0] max_level;
    logic              button_seen;
    logic              in_setup;
  } result_t;

endpackage

`default_nettype wire

[hdl/pbfd_if.sv]
`default_nettype none

// Tick channel
interface pbfd_in_if;
  logic       valid;
  logic       ready;
  logic       button_level;
  logic       on_write;
  logic       on_value;
  logic       max_write;
  logic [7:0] max_value;

  modport source (output valid, button_level, on_write, on_value, max_write, max_value,
                  input ready);
  modport sink   (input valid, button_level, on_write, on_value, max_write, max_value,
                  output ready);
endinterface

// Result channel
interface pbfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_level;
  logic       power_enable;
  logic       lamp_on;
  logic [7:0] max_level;
  logic       button_seen;
  logic       in_setup;

  modport source (output valid, pwm_level, power_enable, lamp_on, max_level, button_seen,
                  in_setup, input ready);
  modport sink   (input valid, pwm_level, power_enable, lamp_on, max_level, button_seen,
                  in_setup, output ready);
endinterface

`default_nettype wire

[hdl/push_button_fading_dimmer.sv]
// Push-button fading dimmer. Each transfer on in_ch is one millisecond tick
// carrying the raw button level and optional bus writes of the on bit and the
// maximum level; every tick yields exactly one result on out_ch, in the cycle
// after its transfer, holding the lamp level, power enable and the bus
// readbacks after that tick. A tick is taken in every cycle: the whole update
// is one pass of compare-and-add logic between the state registers and the
// output register, and in_ch.ready is low only while the output register
// holds a result that out_ch is not taking. Timer registers (debounce, fade
// period, long press) and step sizes are written through cfg_we/cfg_index/
// cfg_data; the user must do so while no tick is in flight (not enforced).
`default_nettype none

module push_button_fading_dimmer #(
  parameter int TIMER_WIDTH = 16,
  parameter int LEVEL_WIDTH = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  pbfd_in_if.sink                              in_ch,
  pbfd_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [pbfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pbfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pbfd_pkg::*;

  cfg_t    cfg;
  tick_t   tick;
  result_t res;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    in_xfer;

  pbfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input transfer
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign tick.button_level = in_ch.button_level;
  assign tick.on_write     = in_ch.on_write;
  assign tick.on_value     = in_ch.on_value;
  assign tick.max_write    = in_ch.max_write;
  assign tick.max_value    = in_ch.max_value;

  pbfd_core #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .LEVEL_WIDTH (LEVEL_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_xfer),
    .tick   (tick),
    .cfg    (cfg),
    .res    (res)
  );

  // Output register
  assign out_valid_nxt = in_xfer || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pwm_level    = res_r.pwm_level;
  assign out_ch.power_enable = res_r.power_enable;
  assign out_ch.lamp_on      = res_r.lamp_on;
  assign out_ch.max_level    = res_r.max_level;
  assign out_ch.button_seen  = res_r.button_seen;
  assign out_ch.in_setup     = res_r.in_setup;

endmodule

`default_nettype wire

[hdl/pbfd_cfg.sv]
`default_nettype none

module pbfd_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pbfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pbfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output pbfd_pkg::cfg_t                      cfg
);
  import pbfd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register decode; writes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_DEBOUNCE:    cfg_nxt.debounce_ticks    = cfg_data[TICK_W-1:0];
        REG_FADE_PERIOD: cfg_nxt.fade_period_ticks = cfg_data[TICK_W-1:0];
        REG_HOLD_LIMIT:  cfg_nxt.hold_limit_ticks  = cfg_data[TICK_W-1:0];
        REG_FADE_STEP:   cfg_nxt.fade_step         = cfg_data[STEP_W-1:0];
        REG_SWEEP_STEP:  cfg_nxt.sweep_step        = cfg_data[STEP_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks    <= DEBOUNCE_RST;
      cfg_r.fade_period_ticks <= FADE_PERIOD_RST;
      cfg_r.hold_limit_ticks  <= HOLD_LIMIT_RST;
      cfg_r.fade_step         <= FADE_STEP_RST;
      cfg_r.sweep_step        <= SWEEP_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hdl/pbfd_core.sv]
`default_nettype none
`include "push_button_fading_dimmer_assert.svh"

module pbfd_core #(
  parameter int TIMER_WIDTH = 16,
  parameter int LEVEL_WIDTH = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire pbfd_pkg::tick_t tick,
  input  wire pbfd_pkg::cfg_t  cfg,
  output pbfd_pkg::result_t  res
);
  import pbfd_pkg::*;

  localparam int LW = LEVEL_WIDTH;
  localparam int TW = TIMER_WIDTH;
  // Counters are compared against 16-bit registers at the wider of the two
  localparam int CW = (TW > TICK_W) ? TW : TICK_W;
  localparam int SW = STEP_W + 1;
  localparam logic [LW-1:0] LEVEL_MAX = {LW{1'b1}};
  localparam logic [TW-1:0] TIMER_MAX = {TW{1'b1}};

  logic                 light_on_r, light_on_nxt;
  logic                 bus_on_r, bus_on_nxt;
  logic [LW-1:0]        bus_max_r, bus_max_nxt;
  logic [LW-1:0]        light_max_r, light_max_nxt;
  logic [LW-1:0]        level_r, level_nxt;
  logic [LW-1:0]        target_r, target_nxt;
  logic signed [SW-1:0] delta_r, delta_nxt;
  logic                 setup_r, setup_nxt;
  logic                 pressed_r, pressed_nxt;
  logic                 debouncing_r, debouncing_nxt;
  logic [TW-1:0]        deb_cnt_r, deb_cnt_nxt;
  logic [TW-1:0]        fade_cnt_r, fade_cnt_nxt;
  logic [TW-1:0]        hold_cnt_r, hold_cnt_nxt;
  logic                 power_r, power_nxt;
  logic                 sample_r, sample_nxt;

  logic signed [SW-1:0] fade_pos, sweep_pos;

  assign fade_pos  = $signed({1'b0, cfg.fade_step});
  assign sweep_pos = $signed({1'b0, cfg.sweep_step});

  function automatic logic [TW-1:0] tick_up(input logic [TW-1:0] c);
    tick_up = (c != TIMER_MAX) ? c + 1'b1 : c;
  endfunction

  // Whole tick update, in the order the behaviour defines
  always_comb begin
    logic                 down_v;
    logic signed [LW+1:0] sum_v;
    light_on_nxt   = light_on_r;
    bus_on_nxt     = bus_on_r;
    bus_max_nxt    = bus_max_r;
    light_max_nxt  = light_max_r;
    level_nxt      = level_r;
    target_nxt     = target_r;
    delta_nxt      = delta_r;
    setup_nxt      = setup_r;
    pressed_nxt    = pressed_r;
    debouncing_nxt = debouncing_r;
    deb_cnt_nxt    = deb_cnt_r;
    fade_cnt_nxt   = fade_cnt_r;
    hold_cnt_nxt   = hold_cnt_r;
    power_nxt      = power_r;
    sample_nxt     = sample_r;
    down_v         = 1'b0;
    sum_v          = '0;

    if (accept) begin
      // bus writes
      if (tick.on_write)  bus_on_nxt  = tick.on_value;
      if (tick.max_write) bus_max_nxt = LW'(tick.max_value);

      // elapsed-time counters, saturating
      deb_cnt_nxt  = tick_up(deb_cnt_r);
      fade_cnt_nxt = tick_up(fade_cnt_r);
      if (pressed_r) hold_cnt_nxt = tick_up(hold_cnt_r);

      // follow a bus-side on/off change
      if (bus_on_nxt != light_on_nxt) begin
        if (light_on_nxt) begin
          light_on_nxt = 1'b0;
          target_nxt   = '0;
          delta_nxt    = -fade_pos;
        end else begin
          light_on_nxt = 1'b1;
          target_nxt   = light_max_nxt;
          delta_nxt    = fade_pos;
        end
      end

      // follow a bus-side maximum change
      if (bus_max_nxt != light_max_nxt) begin
        light_max_nxt = bus_max_nxt;
        if (light_on_nxt) begin
          delta_nxt  = (level_nxt > light_max_nxt) ? -fade_pos : fade_pos;
          target_nxt = light_max_nxt;
        end
      end

      // debounce and press/release handling
      if (!debouncing_r || (CW'(deb_cnt_nxt) >= CW'(cfg.debounce_ticks))) begin
        sample_nxt = tick.button_level;
        down_v     = !tick.button_level;
        if (down_v != pressed_nxt) begin
          hold_cnt_nxt = '0;
          if (down_v) begin
            if (light_on_nxt) begin
              light_on_nxt = 1'b0;
              target_nxt   = '0;
              delta_nxt    = -fade_pos;
            end else begin
              light_on_nxt = 1'b1;
              target_nxt   = light_max_nxt;
              delta_nxt    = fade_pos;
            end
            bus_on_nxt  = light_on_nxt;
            pressed_nxt = 1'b1;
          end else begin
            if (setup_nxt) begin
              setup_nxt     = 1'b0;
              light_max_nxt = level_nxt;
              delta_nxt     = '0;
              bus_max_nxt   = level_nxt;
            end
            pressed_nxt = 1'b0;
          end
          debouncing_nxt = 1'b1;
        end else begin
          debouncing_nxt = 1'b0;
        end
        deb_cnt_nxt = '0;
      end

      // long press starts the setup sweep
      if (pressed_nxt && !setup_nxt &&
          (CW'(hold_cnt_nxt) > CW'(cfg.hold_limit_ticks))) begin
        setup_nxt = 1'b1;
        if (level_nxt == '0) begin
          delta_nxt  = sweep_pos;
          target_nxt = LEVEL_MAX;
        end else begin
          delta_nxt  = -sweep_pos;
          target_nxt = '0;
        end
      end

      // fade step
      if (CW'(fade_cnt_nxt) >= CW'(cfg.fade_period_ticks)) begin
        fade_cnt_nxt = '0;
        if (delta_nxt != '0) begin
          sum_v = $signed({2'b00, level_nxt}) + $signed({{(LW-7){delta_nxt[SW-1]}}, delta_nxt});
          if (!delta_nxt[SW-1]) begin
            if (sum_v > $signed({2'b00, target_nxt})) begin
              level_nxt = target_nxt;
              if (setup_nxt) begin
                delta_nxt  = -delta_nxt;
                target_nxt = '0;
              end else begin
                delta_nxt = '0;
              end
            end else begin
              level_nxt = sum_v[LW-1:0];
            end
            power_nxt = 1'b1;
          end else begin
            if (sum_v < $signed({2'b00, target_nxt})) begin
              level_nxt = target_nxt;
              if (setup_nxt) begin
                delta_nxt  = -delta_nxt;
                target_nxt = LEVEL_MAX;
              end else begin
                delta_nxt = '0;
                if (level_nxt == '0) power_nxt = 1'b0;
              end
            end else begin
              level_nxt = sum_v[LW-1:0];
            end
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_on_r   <= 1'b0;
      bus_on_r     <= 1'b0;
      bus_max_r    <= LW'(255);
      light_max_r  <= LW'(255);
      level_r      <= '0;
      target_r     <= '0;
      delta_r      <= '0;
      setup_r      <= 1'b0;
      pressed_r    <= 1'b0;
      debouncing_r <= 1'b0;
      deb_cnt_r    <= '0;
      fade_cnt_r   <= '0;
      hold_cnt_r   <= '0;
      power_r      <= 1'b0;
      sample_r     <= 1'b1;
    end else begin
      light_on_r   <= light_on_nxt;
      bus_on_r     <= bus_on_nxt;
      bus_max_r    <= bus_max_nxt;
      light_max_r  <= light_max_nxt;
      level_r      <= level_nxt;
      target_r     <= target_nxt;
      delta_r      <= delta_nxt;
      setup_r      <= setup_nxt;
      pressed_r    <= pressed_nxt;
      debouncing_r <= debouncing_nxt;
      deb_cnt_r    <= deb_cnt_nxt;
      fade_cnt_r   <= fade_cnt_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
      power_r      <= power_nxt;
      sample_r     <= sample_nxt;
    end
  end

  // Result of this tick, taken by the output register on transfer
  assign res.pwm_level    = level_nxt[BYTE_W-1:0];
  assign res.power_enable = power_nxt;
  assign res.lamp_on      = bus_on_nxt;
  assign res.max_level    = bus_max_nxt[BYTE_W-1:0];
  assign res.button_seen  = sample_nxt;
  assign res.in_setup     = setup_nxt;

  // Bus readback and internal light state never disagree between ticks
  `PBFD_ASSERT_IMP(a_on_match, clk, rst_n, 1'b1, light_on_r == bus_on_r)
  `PBFD_ASSERT_IMP(a_max_match, clk, rst_n, 1'b1, light_max_r == bus_max_r)
  // Setup sweep only runs while the button is held
  `PBFD_ASSERT_IMP(a_setup_held, clk, rst_n, setup_r, pressed_r)
  // Power drops only once the lamp is fully dark
  `PBFD_ASSERT_IMP(a_power_off_dark, clk, rst_n, $fell(power_r), level_r == '0)
  // No state moves without a tick transfer
  `PBFD_ASSERT_NXT(a_idle_hold, clk, rst_n, !accept, $stable(level_r) && $stable(delta_r))

endmodule

`default_nettype wire
